FILE: hdl/ggm_pkg.sv
// Shared types and constants for the grey-to-glyph matcher.
`default_nettype none

package ggm_pkg;

  // Field widths fixed by the stream format.
  localparam int LEVEL_W     = 8;
  localparam int GAIN_W      = 10;
  localparam int CODE_W      = 7;
  localparam int GREY_W      = 8;
  localparam int IN_RAW_W    = 16;
  localparam int IDX_FIELD_W = 7;
  localparam int FUNC_W      = 2;
  localparam int PROD_W      = GREY_W + GAIN_W;

  // Operation selector carried in tuser.
  typedef logic [FUNC_W-1:0] func_t;
  localparam func_t FUNC_LOAD     = 2'd0;
  localparam func_t FUNC_FINALIZE = 2'd1;
  localparam func_t FUNC_PIXEL    = 2'd2;

  // Level and code constants.
  localparam logic [LEVEL_W-1:0] WHITE_LEVEL = 8'd255;
  localparam logic [LEVEL_W-1:0] HALF_LSB    = 8'd128;
  localparam logic [CODE_W-1:0]  SPACE_CODE  = 7'd32;
  localparam logic [CODE_W-1:0]  FIRST_GLYPH = 7'd33;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 10'd256;

  // The level divider produces one quotient bit per step.
  localparam int STEP_W    = 3;
  localparam int DIV_STEPS = 8;

endpackage

`default_nettype wire

FILE: hdl/ggm_level_div.sv
// Iterative divider that turns one raw darkness value into a glyph level.
`default_nettype none

module ggm_level_div
  import ggm_pkg::*;
#(
  parameter int RAW_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [RAW_WIDTH-1:0] raw,
  input  wire logic [RAW_WIDTH-1:0] raw_max,
  output logic                      done,
  output logic [LEVEL_W-1:0]        level
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FINISH} div_state_t;

  localparam int NUM_W = RAW_WIDTH + LEVEL_W;

  div_state_t             state_r;
  logic                   done_r;
  logic [LEVEL_W-1:0]     level_r;
  logic [STEP_W-1:0]      step_r;
  logic [RAW_WIDTH-1:0]   max_r;
  logic [RAW_WIDTH-1:0]   rem_r;
  logic [LEVEL_W-1:0]     low_r;
  logic [LEVEL_W-1:0]     quo_r;

  logic [NUM_W-1:0]       num;
  logic [RAW_WIDTH-1:0]   num_hi;
  logic                   num_over;
  logic [RAW_WIDTH:0]     trial;
  logic                   trial_ge;
  logic [RAW_WIDTH:0]     trial_diff;
  logic [LEVEL_W:0]       ceil_sum;
  logic [LEVEL_W-1:0]     level_nxt;

  // raw * 255 as a shift and subtract; the high part seeds the remainder.
  assign num      = {raw, {LEVEL_W{1'b0}}} - NUM_W'(raw);
  assign num_hi   = num[NUM_W-1:LEVEL_W];
  assign num_over = (num_hi >= raw_max);

  // One restoring step: bring down the next numerator bit and try a subtract.
  assign trial      = {rem_r, low_r[LEVEL_W-1]};
  assign trial_ge   = (trial >= {1'b0, max_r});
  assign trial_diff = trial - {1'b0, max_r};

  // Round the quotient up when a remainder is left, then flip to a level.
  assign ceil_sum  = {1'b0, quo_r} + (LEVEL_W+1)'(rem_r != '0);
  assign level_nxt = ceil_sum[LEVEL_W] ? '0 : (WHITE_LEVEL - ceil_sum[LEVEL_W-1:0]);

  // Sequencer with its registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
      level_r <= '0;
      step_r  <= '0;
    end else begin
      unique case (state_r)
        D_IDLE: begin
          step_r <= '0;
          done_r <= start && ((raw_max == '0) || num_over);
          if (start) begin
            if (raw_max == '0) begin
              level_r <= WHITE_LEVEL;
            end else if (num_over) begin
              level_r <= '0;
            end else begin
              state_r <= D_RUN;
            end
          end
        end
        D_RUN: begin
          done_r <= 1'b0;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(DIV_STEPS - 1)) begin
            state_r <= D_FINISH;
          end
        end
        D_FINISH: begin
          level_r <= level_nxt;
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: begin
          done_r  <= 1'b0;
          state_r <= D_IDLE;
        end
      endcase
    end
  end

  // Datapath registers of the division.
  always_ff @(posedge clk) begin
    if (state_r == D_IDLE && start) begin
      max_r <= raw_max;
      rem_r <= num_hi;
      low_r <= num[LEVEL_W-1:0];
      quo_r <= '0;
    end else if (state_r == D_RUN) begin
      rem_r <= trial_ge ? trial_diff[RAW_WIDTH-1:0] : trial[RAW_WIDTH-1:0];
      low_r <= {low_r[LEVEL_W-2:0], 1'b0};
      quo_r <= {quo_r[LEVEL_W-2:0], trial_ge};
    end
  end

  assign done  = done_r;
  assign level = level_r;

  // The partial remainder always stays below the divisor.
  a_rem_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == D_RUN || state_r == D_FINISH) |-> (rem_r < max_r))
    else $error("divider remainder not below divisor");

  // A new division is only started while the divider is idle.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == D_IDLE))
    else $error("divider started while busy");

endmodule

`default_nettype wire

FILE: hdl/grey_to_glyph_matcher.sv
// Top level of the grey-to-glyph matcher: glyph tables, contrast and nearest-level scan.
//
// Usage: words arrive on the in_ stream; in_tuser selects the operation.
// Load stores one raw darkness value and updates the running maximum in the
// cycle it is accepted. Finalize converts every raw entry to an 8-bit glyph
// level with an 8-step divider, one entry after another; the divider skips
// its steps when the maximum is zero.
// Pixel applies the contrast gain (one multiply, then round half to even and
// saturate), then scans the level memory one entry per cycle through its
// single read port. A white pixel skips the scan.
// Load and unused codes produce no result word; finalize produces none.
// The block takes one word at a time; in_tready is high when idle with none pending.
// A result sits in the output register until out_tready takes it, and the
// block keeps accepting words meanwhile; a second result waits for the slot
// and holds in_tready low until it moves into the output register.
// Reset clears the maximum, sets the gain to 1.0 and empties the output.
// The tables hold nothing useful until loaded and finalized.
`default_nettype none

module grey_to_glyph_matcher
  import ggm_pkg::*;
#(
  parameter int GLYPH_COUNT = 94,
  parameter int RAW_WIDTH   = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Configuration: contrast gain in units of 1/256.
  input  wire logic              cfg_wr_en,
  input  wire logic [GAIN_W-1:0] cfg_wr_data,
  // Input stream.
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [31:0]       in_tdata,  // entry_index[6:0], raw_darkness[22:7], grey_pixel[30:23]
  input  wire logic [FUNC_W-1:0] in_tuser,  // func[1:0]
  // Result stream.
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata  // char_code[6:0]
);

  localparam int IDX_W = $clog2(GLYPH_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GLYPH_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_FIN_READ, S_FIN_START, S_FIN_DIV,
    S_GAIN, S_ROUND, S_SCAN, S_SCAN_LAST
  } state_t;

  // Result stage is tracked separately so it can wait for the output slot.
  state_t                state_r;
  logic                  result_pend_r;
  logic                  out_tvalid_r;
  logic [CODE_W-1:0]     out_code_r;
  logic [GAIN_W-1:0]     gain_r;
  logic [RAW_WIDTH-1:0]  max_r;
  logic [IDX_W-1:0]      fin_idx_r;
  logic [IDX_W-1:0]      scan_addr_r;
  logic                  cmp_vld_r;
  logic [IDX_W-1:0]      cmp_idx_r;
  logic [IDX_W-1:0]      best_idx_r;
  logic [LEVEL_W-1:0]    best_dist_r;
  logic                  white_r;
  logic [GREY_W-1:0]     grey_r;
  logic [PROD_W-1:0]     prod_r;
  logic [LEVEL_W-1:0]    v_r;

  logic [RAW_WIDTH-1:0]  raw_mem [GLYPH_COUNT];
  logic [LEVEL_W-1:0]    glyph_mem [GLYPH_COUNT];
  logic [RAW_WIDTH-1:0]  raw_rd_r;
  logic [LEVEL_W-1:0]    glyph_rd_r;

  // Unpacked input fields.
  logic [IDX_FIELD_W-1:0] in_idx;
  logic [IN_RAW_W-1:0]    in_raw_field;
  logic [GREY_W-1:0]      in_grey;
  func_t                  in_func;
  logic [RAW_WIDTH-1:0]   in_raw;
  logic                   in_acc;
  logic                   entry_ok;
  logic                   raw_we;
  logic                   glyph_we;

  logic                   div_start;
  logic                   div_done;
  logic [LEVEL_W-1:0]     div_level;

  logic [GAIN_W-1:0]      q_trunc;
  logic [LEVEL_W-1:0]     frac;
  logic                   round_up;
  logic [GAIN_W:0]        q_rnd;
  logic [LEVEL_W-1:0]     v_nxt;
  logic [LEVEL_W-1:0]     lvl_diff;
  logic                   best_upd;
  logic                   slot_free;
  logic [CODE_W-1:0]      code_nxt;

  assign in_idx       = in_tdata[IDX_FIELD_W-1:0];
  assign in_raw_field = in_tdata[IDX_FIELD_W +: IN_RAW_W];
  assign in_grey      = in_tdata[IDX_FIELD_W + IN_RAW_W +: GREY_W];
  assign in_func      = in_tuser;
  assign in_raw       = RAW_WIDTH'(in_raw_field);

  assign in_tready = (state_r == S_IDLE) && !result_pend_r;
  assign in_acc    = in_tvalid && in_tready;
  assign entry_ok  = (32'(in_idx) < 32'(GLYPH_COUNT));
  assign raw_we    = in_acc && (in_func == FUNC_LOAD) && entry_ok;
  assign glyph_we  = (state_r == S_FIN_DIV) && div_done;
  assign div_start = (state_r == S_FIN_START);
  assign slot_free = !out_tvalid_r || out_tready;

  // Raw darkness memory: written by loads, read during finalize.
  always_ff @(posedge clk) begin
    if (raw_we) begin
      raw_mem[IDX_W'(in_idx)] <= in_raw;
    end
    raw_rd_r <= raw_mem[fin_idx_r];
  end

  // Glyph level memory: written by finalize, scanned by pixels.
  always_ff @(posedge clk) begin
    if (glyph_we) begin
      glyph_mem[fin_idx_r] <= div_level;
    end
    glyph_rd_r <= glyph_mem[scan_addr_r];
  end

  ggm_level_div #(
    .RAW_WIDTH (RAW_WIDTH)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .raw     (raw_rd_r),
    .raw_max (max_r),
    .done    (div_done),
    .level   (div_level)
  );

  // Contrast: round half to even on the registered product, then saturate.
  assign q_trunc  = prod_r[PROD_W-1:LEVEL_W];
  assign frac     = prod_r[LEVEL_W-1:0];
  assign round_up = (frac > HALF_LSB) || ((frac == HALF_LSB) && q_trunc[0]);
  assign q_rnd    = {1'b0, q_trunc} + (GAIN_W+1)'(round_up);
  assign v_nxt    = (q_rnd > (GAIN_W+1)'(WHITE_LEVEL)) ? WHITE_LEVEL : q_rnd[LEVEL_W-1:0];

  // Distance of the level just read; only a strictly closer entry wins.
  assign lvl_diff = (glyph_rd_r > v_r) ? (glyph_rd_r - v_r) : (v_r - glyph_rd_r);
  assign best_upd = cmp_vld_r && ((cmp_idx_r == '0) || (lvl_diff < best_dist_r));
  assign code_nxt = white_r ? SPACE_CODE : (CODE_W'(best_idx_r) + FIRST_GLYPH);

  // Main sequencer with registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      result_pend_r <= 1'b0;
      out_tvalid_r  <= 1'b0;
      gain_r        <= GAIN_RESET;
      max_r         <= '0;
      fin_idx_r     <= '0;
      scan_addr_r   <= '0;
      cmp_vld_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        gain_r <= cfg_wr_data;
      end
      if (result_pend_r && slot_free) begin
        out_tvalid_r  <= 1'b1;
        result_pend_r <= 1'b0;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      cmp_vld_r <= (state_r == S_SCAN);

      unique case (state_r)
        S_IDLE: begin
          fin_idx_r   <= '0;
          scan_addr_r <= '0;
          if (in_acc) begin
            case (in_func)
              FUNC_LOAD: begin
                if (entry_ok && (in_raw > max_r)) begin
                  max_r <= in_raw;
                end
              end
              FUNC_FINALIZE: state_r <= S_FIN_READ;
              FUNC_PIXEL:    state_r <= S_GAIN;
              default:       state_r <= S_IDLE;
            endcase
          end
        end
        S_FIN_READ:  state_r <= S_FIN_START;
        S_FIN_START: state_r <= S_FIN_DIV;
        S_FIN_DIV: begin
          if (div_done) begin
            if (fin_idx_r == LAST_IDX) begin
              state_r <= S_IDLE;
            end else begin
              fin_idx_r <= fin_idx_r + 1'b1;
              state_r   <= S_FIN_READ;
            end
          end
        end
        S_GAIN: state_r <= S_ROUND;
        S_ROUND: begin
          if (v_nxt == WHITE_LEVEL) begin
            result_pend_r <= 1'b1;
            state_r       <= S_IDLE;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_addr_r == LAST_IDX) begin
            state_r <= S_SCAN_LAST;
          end else begin
            scan_addr_r <= scan_addr_r + 1'b1;
          end
        end
        S_SCAN_LAST: begin
          result_pend_r <= 1'b1;
          state_r       <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Pixel datapath registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      grey_r <= in_grey;
    end
    if (state_r == S_GAIN) begin
      prod_r <= PROD_W'(grey_r) * PROD_W'(gain_r);
    end
    if (state_r == S_ROUND) begin
      v_r     <= v_nxt;
      white_r <= (v_nxt == WHITE_LEVEL);
    end
    cmp_idx_r <= scan_addr_r;
    if (best_upd) begin
      best_idx_r  <= cmp_idx_r;
      best_dist_r <= lvl_diff;
    end
    if (result_pend_r && slot_free) begin
      out_code_r <= code_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {1'b0, out_code_r};

  // A pixel word always enters the contrast stage next.
  a_pixel_to_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_func == FUNC_PIXEL)) |=> (state_r == S_GAIN))
    else $error("pixel word did not start the contrast stage");

  // Scan and finalize addresses stay inside the table.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (32'(scan_addr_r) < 32'(GLYPH_COUNT)))
    else $error("scan address beyond glyph table");

  a_fin_range: assert property (@(posedge clk) disable iff (!rst_n)
    glyph_we |-> (32'(fin_idx_r) < 32'(GLYPH_COUNT)))
    else $error("finalize index beyond glyph table");

  // A result word only appears after a pending result was posted.
  a_out_from_pend: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(result_pend_r))
    else $error("result word without a pending result");

endmodule

`default_nettype wire
